### hw/rtl/sbmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_pkg
// shared types, sizes and codes of the shared buffer multi queue unit
// ----------------------------------------------------------------------------
package sbmq_pkg;

	// buffer and queue sizes (both powers of two)
	localparam int ENTRIES   = 256;
	localparam int QUEUES    = 128;
	localparam int WORD_BITS = 32;

	localparam int ENT_W  = $clog2(ENTRIES);
	localparam int Q_W    = $clog2(QUEUES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	// fixed port field widths
	localparam int MODE_W = 3;
	localparam int QID_W  = 7;
	localparam int ST_W   = 2;

	typedef logic [ENT_W-1:0]     ent_t;
	typedef logic [Q_W-1:0]       qix_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_REMOVE = 3'd1,
		MODE_QUERY  = 3'd2,
		MODE_MOVE   = 3'd3,
		MODE_COPY   = 3'd4
	} mode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_TGT_EMPTY = 2'd1,
		ST_FULL      = 2'd2,
		ST_SRC_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK,
		S_POP,
		S_PUSH,
		S_HEAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic rd_in;    // capture item, read queue tables
		logic rd_link;  // read links and source word
		logic wr_pop;   // unlink head
		logic wr_push;  // link entry at tail, update free list
		logic ld_out;   // load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_pop;
	} stat_t;

endpackage

### hw/rtl/sbmq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_dp
// queue tables, link and word memories, free list and result register
// ----------------------------------------------------------------------------
module sbmq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sbmq_pkg::cmd_t                cmd,
	output sbmq_pkg::stat_t               stat,
	input  logic [sbmq_pkg::MODE_W-1:0]   mode,
	input  logic [sbmq_pkg::QID_W-1:0]    queue_id,
	input  logic [sbmq_pkg::QID_W-1:0]    source_queue,
	input  logic [sbmq_pkg::WORD_BITS-1:0] payload_value,
	output logic [sbmq_pkg::WORD_BITS-1:0] head_value,
	output logic [sbmq_pkg::CNT_W-1:0]    queue_length,
	output logic [sbmq_pkg::ST_W-1:0]     status
);

	// memories
	sbmq_pkg::word_t payload_mem [sbmq_pkg::ENTRIES];
	sbmq_pkg::ent_t  link_mem    [sbmq_pkg::ENTRIES];
	sbmq_pkg::ent_t  head_mem    [sbmq_pkg::QUEUES];
	sbmq_pkg::ent_t  tail_mem    [sbmq_pkg::QUEUES];
	sbmq_pkg::cnt_t  cnt_mem     [sbmq_pkg::QUEUES];

	// written marks for stores with a reset value
	logic [sbmq_pkg::ENTRIES-1:0] link_vld_q;
	logic [sbmq_pkg::QUEUES-1:0]  cnt_vld_q;

	// captured item
	sbmq_pkg::mode_t mode_q;
	sbmq_pkg::qix_t  q_q, s_q;
	sbmq_pkg::word_t word_q;

	// registered reads
	sbmq_pkg::ent_t  hq_rd_q, hs_rd_q, tq_rd_q;
	sbmq_pkg::cnt_t  cq_rd_q, cs_rd_q;
	logic            cq_vld_q, cs_vld_q;
	sbmq_pkg::ent_t  lp_rd_q, lf_rd_q;
	logic            lp_vld_q, lf_vld_q;
	sbmq_pkg::word_t w_src_q;

	// free list
	sbmq_pkg::ent_t  free_head_q;
	sbmq_pkg::cnt_t  free_cnt_q;

	// target view after the operation
	sbmq_pkg::ent_t    head_fin_q;
	sbmq_pkg::cnt_t    cnt_fin_q;
	sbmq_pkg::status_t status_fin_q;

	// result register
	sbmq_pkg::word_t   head_out_q;
	sbmq_pkg::cnt_t    len_out_q;
	sbmq_pkg::status_t status_out_q;

	// decode
	sbmq_pkg::qix_t    qa, sa;
	sbmq_pkg::cnt_t    cq, cs, cp, cq_after, cnt_fin;
	sbmq_pkg::ent_t    link_pop, link_free, pop_ent, push_ent, head_fin;
	sbmq_pkg::qix_t    pop_qix;
	sbmq_pkg::word_t   push_word;
	sbmq_pkg::status_t status_now;
	logic              do_pop, do_push, free_empty, same_q;

	// write ports
	logic            head_we, link_we, cnt_we, tail_we, pay_we;
	sbmq_pkg::qix_t  head_wa, cnt_wa;
	sbmq_pkg::ent_t  head_wd, link_wa, link_wd;
	sbmq_pkg::cnt_t  cnt_wd;

	assign qa = queue_id[sbmq_pkg::Q_W-1:0];
	assign sa = source_queue[sbmq_pkg::Q_W-1:0];

	assign cq = cq_vld_q ? cq_rd_q : '0;
	assign cs = cs_vld_q ? cs_rd_q : '0;

	// unwritten link entries point to the next index
	assign link_pop  = lp_vld_q ? lp_rd_q : sbmq_pkg::ent_t'(pop_ent + 1'b1);
	assign link_free = lf_vld_q ? lf_rd_q : sbmq_pkg::ent_t'(free_head_q + 1'b1);

	assign free_empty = (free_cnt_q == '0);

	always_comb begin
		do_pop     = 1'b0;
		do_push    = 1'b0;
		status_now = sbmq_pkg::ST_OK;
		unique case (mode_q)
			sbmq_pkg::MODE_APPEND: begin
				do_push = !free_empty;
				if (free_empty)
					status_now = sbmq_pkg::ST_FULL;
			end
			sbmq_pkg::MODE_REMOVE: begin
				do_pop = (cq != '0);
				if (cq == '0)
					status_now = sbmq_pkg::ST_TGT_EMPTY;
			end
			sbmq_pkg::MODE_MOVE: begin
				// freed head is reused at once, so never full
				do_pop  = (cs != '0);
				do_push = (cs != '0);
				if (cs == '0)
					status_now = sbmq_pkg::ST_SRC_EMPTY;
			end
			sbmq_pkg::MODE_COPY: begin
				do_push = (cs != '0) && !free_empty;
				if (cs == '0)
					status_now = sbmq_pkg::ST_SRC_EMPTY;
				else if (free_empty)
					status_now = sbmq_pkg::ST_FULL;
			end
			default: begin
				// query and unused codes
			end
		endcase
	end

	always_comb begin
		if (mode_q == sbmq_pkg::MODE_REMOVE) begin
			pop_qix = q_q;
			pop_ent = hq_rd_q;
			cp      = cq;
		end else begin
			pop_qix = s_q;
			pop_ent = hs_rd_q;
			cp      = cs;
		end
		push_ent  = (mode_q == sbmq_pkg::MODE_MOVE) ? hs_rd_q : free_head_q;
		push_word = (mode_q == sbmq_pkg::MODE_APPEND) ? word_q : w_src_q;
		same_q    = do_pop && (pop_qix == q_q);
		cq_after  = same_q ? sbmq_pkg::cnt_t'(cq - 1'b1) : cq;
		cnt_fin   = do_push ? sbmq_pkg::cnt_t'(cq_after + 1'b1) : cq_after;
		if (do_push && (cq_after == '0))
			head_fin = push_ent;
		else if (same_q)
			head_fin = link_pop;
		else
			head_fin = hq_rd_q;
	end

	assign stat.need_pop = do_pop;

	// write port selection: pop and push steps never overlap
	always_comb begin
		head_we = 1'b0;
		head_wa = pop_qix;
		head_wd = link_pop;
		cnt_we  = 1'b0;
		cnt_wa  = pop_qix;
		cnt_wd  = sbmq_pkg::cnt_t'(cp - 1'b1);
		link_we = 1'b0;
		link_wa = pop_ent;
		link_wd = free_head_q;
		if (cmd.wr_pop && do_pop) begin
			head_we = 1'b1;
			cnt_we  = 1'b1;
			link_we = (mode_q == sbmq_pkg::MODE_REMOVE);
		end
		if (cmd.wr_push && do_push) begin
			cnt_we  = 1'b1;
			cnt_wa  = q_q;
			cnt_wd  = cnt_fin;
			head_wa = q_q;
			head_wd = push_ent;
			link_wa = tq_rd_q;
			link_wd = push_ent;
			if (cq_after == '0)
				head_we = 1'b1;
			else
				link_we = 1'b1;
		end
	end

	assign tail_we = cmd.wr_push && do_push;
	assign pay_we  = cmd.wr_push && do_push;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.rd_in) begin
			mode_q <= sbmq_pkg::mode_t'(mode);
			q_q    <= qa;
			s_q    <= sa;
			word_q <= payload_value[sbmq_pkg::WORD_BITS-1:0];
		end
	end

	// queue head and tail tables
	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		if (cmd.rd_in) begin
			hq_rd_q <= head_mem[qa];
			hs_rd_q <= head_mem[sa];
		end
	end

	always_ff @(posedge clk) begin
		if (tail_we)
			tail_mem[q_q] <= push_ent;
		if (cmd.rd_in)
			tq_rd_q <= tail_mem[qa];
	end

	// queue counts
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_wa] <= cnt_wd;
		if (cmd.rd_in) begin
			cq_rd_q <= cnt_mem[qa];
			cs_rd_q <= cnt_mem[sa];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			cq_vld_q  <= 1'b0;
			cs_vld_q  <= 1'b0;
		end else begin
			if (cnt_we)
				cnt_vld_q[cnt_wa] <= 1'b1;
			if (cmd.rd_in) begin
				cq_vld_q <= cnt_vld_q[qa];
				cs_vld_q <= cnt_vld_q[sa];
			end
		end
	end

	// links
	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (cmd.rd_link) begin
			lp_rd_q <= link_mem[pop_ent];
			lf_rd_q <= link_mem[free_head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			lp_vld_q   <= 1'b0;
			lf_vld_q   <= 1'b0;
		end else begin
			if (link_we)
				link_vld_q[link_wa] <= 1'b1;
			if (cmd.rd_link) begin
				lp_vld_q <= link_vld_q[pop_ent];
				lf_vld_q <= link_vld_q[free_head_q];
			end
		end
	end

	// words
	always_ff @(posedge clk) begin
		if (pay_we)
			payload_mem[push_ent] <= push_word;
		if (cmd.rd_link)
			w_src_q <= payload_mem[hs_rd_q];
		if (cmd.ld_out)
			head_out_q <= payload_mem[head_fin_q];
	end

	// free list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			free_cnt_q  <= sbmq_pkg::cnt_t'(sbmq_pkg::ENTRIES);
		end else if (cmd.wr_push) begin
			if (do_pop && !do_push) begin
				free_head_q <= pop_ent;
				free_cnt_q  <= sbmq_pkg::cnt_t'(free_cnt_q + 1'b1);
			end else if (do_push && !do_pop) begin
				free_head_q <= link_free;
				free_cnt_q  <= sbmq_pkg::cnt_t'(free_cnt_q - 1'b1);
			end
		end
	end

	// target view and result
	always_ff @(posedge clk) begin
		if (cmd.wr_push) begin
			head_fin_q   <= head_fin;
			cnt_fin_q    <= cnt_fin;
			status_fin_q <= status_now;
		end
		if (cmd.ld_out) begin
			len_out_q    <= cnt_fin_q;
			status_out_q <= status_fin_q;
		end
	end

	assign head_value   = (len_out_q != '0) ? head_out_q : '0;
	assign queue_length = len_out_q;
	assign status       = status_out_q;

	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= sbmq_pkg::cnt_t'(sbmq_pkg::ENTRIES))
		else $error("free count above buffer size");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

	a_move_keeps_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_push && (mode_q == sbmq_pkg::MODE_MOVE)) |=> $stable(free_cnt_q))
		else $error("move changed free count");

endmodule

### hw/rtl/sbmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_ctrl
// operation sequencer and result handshake
// ----------------------------------------------------------------------------
module sbmq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sbmq_pkg::stat_t  stat,
	output sbmq_pkg::cmd_t   cmd
);

	sbmq_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sbmq_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sbmq_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.rd_in = 1'b1;
					state_d   = sbmq_pkg::S_LINK;
				end
			end
			sbmq_pkg::S_LINK: begin
				cmd.rd_link = 1'b1;
				state_d     = stat.need_pop ? sbmq_pkg::S_POP : sbmq_pkg::S_PUSH;
			end
			sbmq_pkg::S_POP: begin
				cmd.wr_pop = 1'b1;
				state_d    = sbmq_pkg::S_PUSH;
			end
			sbmq_pkg::S_PUSH: begin
				cmd.wr_push = 1'b1;
				state_d     = sbmq_pkg::S_HEAD;
			end
			sbmq_pkg::S_HEAD: begin
				// wait for the result register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.ld_out = 1'b1;
					state_d    = sbmq_pkg::S_IDLE;
				end
			end
			default: state_d = sbmq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ld_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign in_stall  = (state_q != sbmq_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_reads_links: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> cmd.rd_link)
		else $error("accepted item not sequenced");

	a_pop_then_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_pop |=> cmd.wr_push)
		else $error("pop step not followed by push step");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |=> (out_valid && !in_stall))
		else $error("result load did not raise valid");

endmodule

### hw/rtl/shared_buffer_multi_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// fifo queues sharing one linked entry buffer with a free list
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | fields
//  in      | to block  | in_valid / in_stall   | mode, queue_id, source_queue,
//          |           |                       | payload_value
//  out     | from block| out_valid / out_stall | head_value, queue_length, status
//
// an item holds the block from one acceptance to the next through the link read,
// unlink (only a remove or move that finds an entry), tail link and result load
// steps; the result register loads in the result load step; the single write port
// of each table keeps the unlink and the tail link in separate steps
// the next item is taken while a result still waits in the output register,
// it then holds in its last step until that result leaves
// reset clears the free list, queue counts and link marks at once; no
// clearing pass, so the first item may be accepted right after reset
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// item in
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [sbmq_pkg::MODE_W-1:0]    mode,
	input  logic [sbmq_pkg::QID_W-1:0]     queue_id,
	input  logic [sbmq_pkg::QID_W-1:0]     source_queue,
	input  logic [sbmq_pkg::WORD_BITS-1:0] payload_value,
	// item out
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [sbmq_pkg::WORD_BITS-1:0] head_value,
	output logic [sbmq_pkg::CNT_W-1:0]     queue_length,
	output logic [sbmq_pkg::ST_W-1:0]      status
);

	// command and status between sequencer and datapath
	sbmq_pkg::cmd_t  cmd;
	sbmq_pkg::stat_t stat;

	// sequencer: idle, link read, optional unlink, tail link, result load
	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: head, tail and count tables per queue, link and word
	// memories per entry, free list registers and the result register
	sbmq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (mode),
		.queue_id      (queue_id),
		.source_queue  (source_queue),
		.payload_value (payload_value),
		.head_value    (head_value),
		.queue_length  (queue_length),
		.status        (status)
	);

endmodule

### sim/shared_buffer_multi_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_checker
// watches both channels of the shared buffer multi queue unit, keeps its own
// copy of the linked entry buffer, free list and queue tables, and compares
// every result with the report predicted for the item that caused it
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_checker
	import sbmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [MODE_W-1:0]    mode,
	input  logic [QID_W-1:0]     queue_id,
	input  logic [QID_W-1:0]     source_queue,
	input  logic [WORD_BITS-1:0] payload_value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [WORD_BITS-1:0] head_value,
	input  logic [CNT_W-1:0]     queue_length,
	input  logic [ST_W-1:0]      status,
	output int                   mismatches,
	output int                   pending,
	output int                   compared,
	output int                   full_refusals
);

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		word_t   head;
		cnt_t    len;
		status_t st;
	} queue_report_t;

	word_t entry_word [ENTRIES];
	ent_t  entry_link [ENTRIES];
	ent_t  free_first;
	cnt_t  free_left;
	ent_t  queue_head [QUEUES];
	ent_t  queue_tail [QUEUES];
	cnt_t  queue_len  [QUEUES];

	queue_report_t queue_reports [$];

	task automatic report_mismatch(string what, longint got_v, longint want_v);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got_v, want_v);
		mismatches++;
	endtask

	// take a free entry and hang it at the tail of queue tq
	function automatic bit take_entry(qix_t tq, word_t w);
		ent_t e;
		if (free_left == 0)
			return 1'b0;
		e = free_first;
		free_first = entry_link[e];
		free_left--;
		entry_word[e] = w;
		if (queue_len[tq] == 0)
			queue_head[tq] = e;
		else
			entry_link[queue_tail[tq]] = e;
		queue_tail[tq] = e;
		queue_len[tq]++;
		return 1'b1;
	endfunction

	// unlink the head of a non-empty queue and give its entry back
	function automatic void drop_head(qix_t q);
		ent_t e;
		e = queue_head[q];
		queue_head[q] = entry_link[e];
		queue_len[q]--;
		entry_link[e] = free_first;
		free_first = e;
		free_left++;
	endfunction

	function automatic queue_report_t apply_item(logic [MODE_W-1:0] op, qix_t tq, qix_t sq,
			word_t w);
		queue_report_t r;
		word_t carried;
		r.st = ST_OK;
		case (op)
			MODE_APPEND: begin
				if (!take_entry(tq, w))
					r.st = ST_FULL;
			end
			MODE_REMOVE: begin
				if (queue_len[tq] == 0)
					r.st = ST_TGT_EMPTY;
				else
					drop_head(tq);
			end
			MODE_MOVE, MODE_COPY: begin
				// empty source wins over a full buffer
				if (queue_len[sq] == 0) begin
					r.st = ST_SRC_EMPTY;
				end else begin
					carried = entry_word[queue_head[sq]];
					if (op == MODE_MOVE) begin
						// freed first, so a move always finds an entry
						drop_head(sq);
						void'(take_entry(tq, carried));
					end else if (!take_entry(tq, carried)) begin
						r.st = ST_FULL;
					end
				end
			end
			default: ;
		endcase
		r.len  = queue_len[tq];
		r.head = (queue_len[tq] != 0) ? entry_word[queue_head[tq]] : '0;
		if (r.st == ST_FULL)
			full_refusals++;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				entry_word[i] = '0;
				entry_link[i] = ent_t'(i + 1);
			end
			for (int i = 0; i < QUEUES; i++) begin
				queue_head[i] = '0;
				queue_tail[i] = '0;
				queue_len[i]  = '0;
			end
			free_first = '0;
			free_left  = cnt_t'(ENTRIES);
			queue_reports.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (queue_reports.size() == 0) begin
					report_mismatch("result with nothing expected", head_value, 0);
				end else begin
					want = queue_reports.pop_front();
					compared++;
					if (head_value !== want.head)
						report_mismatch("head_value", head_value, want.head);
					if (queue_length !== want.len)
						report_mismatch("queue_length", queue_length, want.len);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
				end
			end
			if (in_valid && !in_stall)
				queue_reports.push_back(apply_item(mode, qix_t'(queue_id % QUEUES),
					qix_t'(source_queue % QUEUES), payload_value));
			pending = queue_reports.size();
		end
	end

endmodule

### sim/tb_shared_buffer_multi_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue_unit
// drives operations into the shared buffer multi queue unit: a directed
// opening on the corner cases, a fill of the whole buffer under a long
// output hold-off, then random operation mixes under several idle and stall
// patterns; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue_unit;
	import sbmq_pkg::*;

	// codes the block does not define, handled as a query
	localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;

	localparam int FILL_APPENDS  = ENTRIES + 6;   // runs past full on purpose
	localparam int HOLD_CYCLES   = 200;
	localparam int RANDOM_ITEMS  = 180;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_GAP       = 40;

	// how the random operations lean: grow the queues, shrink them, or neither
	typedef enum int {
		MIX_FILL  = 0,
		MIX_DRAIN = 1,
		MIX_EVEN  = 2
	} op_mix_t;

	// cumulative percentages: append, remove, move, copy, query; rest spare codes
	localparam int OP_BOUND [3][5] = '{
		'{55, 65, 75, 90, 97},
		'{15, 65, 80, 85, 97},
		'{30, 58, 73, 85, 97}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [MODE_W-1:0]    mode;
	logic [QID_W-1:0]     queue_id;
	logic [QID_W-1:0]     source_queue;
	logic [WORD_BITS-1:0] payload_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [WORD_BITS-1:0] head_value;
	logic [CNT_W-1:0]     queue_length;
	logic [ST_W-1:0]      status;

	int mismatches;
	int pending;
	int compared;
	int full_refusals;

	// idle and stall rates in percent, changed per phase
	int send_idle_pct;
	int recv_stall_pct;
	// a nonzero value asks the receiver for one long hold-off
	int hold_off_cycles;
	int ops_sent [8];

	shared_buffer_multi_queue_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.queue_id      (queue_id),
		.source_queue  (source_queue),
		.payload_value (payload_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.head_value    (head_value),
		.queue_length  (queue_length),
		.status        (status)
	);

	shared_buffer_multi_queue_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.queue_id      (queue_id),
		.source_queue  (source_queue),
		.payload_value (payload_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.head_value    (head_value),
		.queue_length  (queue_length),
		.status        (status),
		.mismatches    (mismatches),
		.pending       (pending),
		.compared      (compared),
		.full_refusals (full_refusals)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls per cycle, plus the long hold-off when asked
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles != 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
				out_stall <= 1'b1;
				// counted here, the sender keeps offering items meanwhile
				repeat (n) @(negedge clk);
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// offer one item at a falling edge and wait until it is taken
	task automatic send_item(logic [MODE_W-1:0] op, int tq, int sq, word_t w);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= op;
		queue_id      <= QID_W'(tq);
		source_queue  <= QID_W'(sq);
		payload_value <= w;
		ops_sent[op]++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// mostly a handful of queues so lists get deep, now and then any queue
	function automatic int pick_queue();
		return ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(QUEUES - 1);
	endfunction

	task automatic send_random(op_mix_t mix);
		int roll;
		logic [MODE_W-1:0] op;
		roll = $urandom_range(99);
		if (roll < OP_BOUND[mix][0])
			op = MODE_APPEND;
		else if (roll < OP_BOUND[mix][1])
			op = MODE_REMOVE;
		else if (roll < OP_BOUND[mix][2])
			op = MODE_MOVE;
		else if (roll < OP_BOUND[mix][3])
			op = MODE_COPY;
		else if (roll < OP_BOUND[mix][4])
			op = MODE_QUERY;
		else
			op = MODE_SPARE_FIRST + MODE_W'($urandom_range(2));
		send_item(op, pick_queue(), pick_queue(), $urandom());
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		mode            = '0;
		queue_id        = '0;
		source_queue    = '0;
		payload_value   = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed opening, no idling ----
		// queries and refusals on an empty buffer
		send_item(MODE_QUERY,  0,   85,  32'h0000_0000);
		send_item(MODE_REMOVE, 5,   42,  32'h5555_5555);
		send_item(MODE_MOVE,   3,   9,   32'hAAAA_AAAA);
		send_item(MODE_COPY,   0,   127, 32'h1234_5678);
		// extreme words into the extreme queues
		send_item(MODE_APPEND, 127, 0,   32'hFFFF_FFFF);
		send_item(MODE_APPEND, 0,   127, 32'h0000_0000);
		send_item(MODE_APPEND, 127, 0,   32'h8000_0001);
		send_item(MODE_QUERY,  127, 0,   32'h0000_0000);
		send_item(MODE_COPY,   0,   127, 32'h0000_0000);
		// same queue as source and target: head goes to its own tail
		send_item(MODE_MOVE,   127, 127, 32'h0000_0000);
		send_item(MODE_QUERY,  127, 0,   32'h0000_0000);
		send_item(MODE_MOVE,   64,  0,   32'h0000_0000);
		// unused codes behave as a query
		for (int k = 0; k < 3; k++)
			send_item(MODE_SPARE_FIRST + MODE_W'(k), 127, 0, 32'hA5A5_A5A5);
		// empty everything again, with a remove past empty
		send_item(MODE_REMOVE, 0,   0,   32'h0000_0000);
		send_item(MODE_REMOVE, 0,   0,   32'h0000_0000);
		send_item(MODE_REMOVE, 64,  0,   32'h0000_0000);
		send_item(MODE_REMOVE, 127, 0,   32'h0000_0000);
		send_item(MODE_REMOVE, 127, 0,   32'h0000_0000);
		send_item(MODE_REMOVE, 127, 0,   32'h0000_0000);

		// ---- fill the whole buffer while the receiver holds off ----
		// the block backs up and has to stall its input
		hold_off_cycles = HOLD_CYCLES;
		for (int k = 0; k < FILL_APPENDS; k++)
			send_item(MODE_APPEND, $urandom_range(3), $urandom_range(QUEUES - 1), $urandom());
		// buffer is full here
		send_item(MODE_COPY,  1,  0,   32'h0000_0000);   // refused, full
		send_item(MODE_COPY,  2,  100, 32'h0000_0000);   // empty source beats full
		send_item(MODE_MOVE,  5,  0,   32'h0000_0000);   // move still works when full
		send_item(MODE_MOVE,  1,  1,   32'h0000_0000);   // self move while full
		send_item(MODE_QUERY, 5,  0,   32'h0000_0000);

		// ---- random mixes under the idle patterns ----
		for (int k = 0; k < RANDOM_ITEMS - 60; k++)
			send_random(MIX_DRAIN);

		send_idle_pct  = 49;
		recv_stall_pct = 0;
		for (int k = 0; k < RANDOM_ITEMS; k++)
			send_random(MIX_EVEN);

		send_idle_pct  = 0;
		recv_stall_pct = 49;
		for (int k = 0; k < RANDOM_ITEMS; k++)
			send_random(MIX_FILL);

		send_idle_pct  = 11;
		recv_stall_pct = 11;
		for (int k = 0; k < RANDOM_ITEMS; k++)
			send_random(MIX_DRAIN);

		// ---- wind down ----
		in_valid       <= 1'b0;
		recv_stall_pct = 0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("sent %0d appends, %0d removes, %0d queries, %0d moves, %0d copies",
			ops_sent[MODE_APPEND], ops_sent[MODE_REMOVE], ops_sent[MODE_QUERY],
			ops_sent[MODE_MOVE], ops_sent[MODE_COPY]);
		$display("%0d spare codes, compared %0d results, %0d full refusals, %0d mismatches",
			ops_sent[MODE_SPARE_FIRST] + ops_sent[MODE_SPARE_FIRST + 3'd1] +
			ops_sent[MODE_SPARE_FIRST + 3'd2], compared, full_refusals, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/sbmq_pkg.sv
hw/rtl/sbmq_dp.sv
hw/rtl/sbmq_ctrl.sv
hw/rtl/shared_buffer_multi_queue_unit.sv
sim/shared_buffer_multi_queue_checker.sv
sim/tb_shared_buffer_multi_queue_unit.sv
